FILE: rtl/psm_pkg.sv
// Package for the PCM sample mixer: action codes, queue entry type, constants.
// No dependencies.
`timescale 1ns / 1ps
package psm_pkg;
  localparam int unsigned NUM_CHANNELS_DEF = 8;
  localparam int unsigned SAMPLE_DEPTH_DEF = 65536;
  localparam int unsigned GAIN_MAX = 255;
  localparam int unsigned MIX_MAX = 255;
  localparam int unsigned GAIN_SHIFT = 8;
  localparam logic [16:0] MAX_LEN = 17'd65536;

  typedef enum logic [2:0] {
    ACT_START = 3'd0,
    ACT_STOP  = 3'd1,
    ACT_VOL   = 3'd2,
    ACT_LOAD  = 3'd3,
    ACT_TICK  = 3'd4
  } action_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  channel;
    logic        ch_ok;
    logic [15:0] address;
    logic [16:0] length;
    logic        loop_flag;
    logic [7:0]  gain;
    logic [7:0]  sample_data;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_ACC,
    ST_OUT
  } state_t;
endpackage

FILE: rtl/psm_front.sv
// Front end: accepts input requests, classifies them and pushes into a small queue.
// Depends on psm_pkg.
`timescale 1ns / 1ps
module psm_front
  import psm_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        q_pop,
  output logic        q_valid,
  output req_t        q_head
);
  localparam int unsigned DEPTH = 2;

  req_t       mem_r [DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  req_t       cls;
  logic [15:0] vol;
  logic [2:0]  ch;

  assign ch  = in_tdata[5:3];
  assign vol = in_tdata[55:40];

  always_comb begin
    cls.action      = in_tdata[2:0];
    cls.channel     = ch;
    cls.ch_ok       = ({2'b0, ch} < 5'(NUM_CHANNELS));
    cls.address     = in_tdata[21:6];
    cls.length      = (in_tdata[38:22] > MAX_LEN) ? MAX_LEN : in_tdata[38:22];
    cls.loop_flag   = in_tdata[39];
    cls.gain        = (vol > 16'(GAIN_MAX)) ? 8'(GAIN_MAX) : vol[7:0];
    cls.sample_data = in_tdata[64-8 +: 8];
  end

  assign in_tready = (cnt_r != 2'(DEPTH));
  assign q_valid   = (cnt_r != 2'd0);
  assign q_head    = mem_r[rp_r];

  logic push, pop;
  assign push = in_tvalid && in_tready;
  assign pop  = q_pop && q_valid;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end
endmodule

FILE: rtl/psm_back.sv
// Back end: channel registers, sample memory and the per-channel mixing sequencer.
// Depends on psm_pkg.
`timescale 1ns / 1ps
module psm_back
  import psm_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  req_t       q_head,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [15:0] out_tdata
);
  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);
  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [15:0] start_r [NUM_CHANNELS];
  logic [16:0] len_r   [NUM_CHANNELS];
  logic [15:0] pos_r   [NUM_CHANNELS];
  logic [7:0]  gain_r  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] active_r, loop_r;
  logic [7:0]  smem [SAMPLE_DEPTH];
  logic [7:0]  rd_r;

  state_t      st_r, st_nxt;
  logic [CW-1:0] ci_r, ci_nxt;
  logic [8:0]  sum_r, sum_nxt;
  logic        any_r, any_nxt;
  logic        ovld_r, ovld_nxt;
  logic [15:0] odata_r, odata_nxt;
  logic        last_ch;
  logic [CW-1:0] ch;
  logic [AW-1:0] raddr;
  logic [16:0] pos_inc;
  logic [15:0] prod;
  logic [9:0]  acc;

  assign ch      = CW'(q_head.channel);
  assign last_ch = ({1'b0, ci_r} == (CW+1)'(NUM_CHANNELS - 1));
  assign raddr   = AW'({16'd0, start_r[ci_r]} + {16'd0, pos_r[ci_r]});
  assign pos_inc = {1'b0, pos_r[ci_r]} + 17'd1;
  assign prod    = rd_r * gain_r[ci_r];
  assign acc     = {1'b0, sum_r} + {2'b0, prod[15:8]};
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  always_ff @(posedge clk) begin
    if (q_valid && st_r == ST_IDLE && !ovld_r && q_head.action == ACT_LOAD)
      smem[AW'(q_head.address)] <= q_head.sample_data;
    rd_r <= smem[raddr];
  end

  always_comb begin
    st_nxt    = st_r;
    ci_nxt    = ci_r;
    sum_nxt   = sum_r;
    any_nxt   = any_r;
    ovld_nxt  = ovld_r && !out_tready;
    odata_nxt = odata_r;
    q_pop     = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && !ovld_r) begin
          q_pop = 1'b1;
          if (q_head.action == ACT_TICK) begin
            st_nxt  = ST_READ;
            ci_nxt  = '0;
            sum_nxt = '0;
            any_nxt = 1'b0;
          end else begin
            ovld_nxt  = 1'b1;
            odata_nxt = '0;
            if ((q_head.action == ACT_START &&
                 (!q_head.ch_ok || q_head.length == 17'd0)) ||
                ((q_head.action == ACT_STOP || q_head.action == ACT_VOL) &&
                 !q_head.ch_ok))
              odata_nxt[9] = 1'b1;
          end
        end
      end
      ST_READ: st_nxt = active_r[ci_r] ? ST_WAIT : ST_ACC;
      ST_WAIT: st_nxt = ST_ACC;
      ST_ACC: begin
        if (active_r[ci_r]) begin
          any_nxt = 1'b1;
          sum_nxt = (acc > 10'(MIX_MAX)) ? 9'(MIX_MAX) : acc[8:0];
        end
        if (last_ch) st_nxt = ST_OUT;
        else begin
          ci_nxt = ci_r + CW'(1);
          st_nxt = ST_READ;
        end
      end
      ST_OUT: begin
        ovld_nxt  = 1'b1;
        odata_nxt = {6'd0, 1'b0, any_r, any_r ? sum_r[7:0] : 8'd0};
        st_nxt    = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      ovld_r   <= 1'b0;
      active_r <= '0;
      loop_r   <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_r[i] <= '0;
        len_r[i]   <= '0;
        pos_r[i]   <= '0;
        gain_r[i]  <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      ovld_r <= ovld_nxt;
      if (q_pop && q_head.ch_ok) begin
        unique case (q_head.action)
          ACT_START: if (q_head.length != 17'd0) begin
            start_r[ch]  <= q_head.address;
            len_r[ch]    <= q_head.length;
            pos_r[ch]    <= '0;
            loop_r[ch]   <= q_head.loop_flag;
            gain_r[ch]   <= 8'(GAIN_MAX);
            active_r[ch] <= 1'b1;
          end
          ACT_STOP: active_r[ch] <= 1'b0;
          ACT_VOL:  gain_r[ch]   <= q_head.gain;
          default: ;
        endcase
      end
      if (st_r == ST_ACC && active_r[ci_r]) begin
        if (pos_inc >= len_r[ci_r]) begin
          if (loop_r[ci_r]) pos_r[ci_r] <= '0;
          else begin
            pos_r[ci_r]    <= pos_inc[15:0];
            active_r[ci_r] <= 1'b0;
          end
        end else pos_r[ci_r] <= pos_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    ci_r    <= ci_nxt;
    sum_r   <= sum_nxt;
    any_r   <= any_nxt;
    odata_r <= odata_nxt;
  end
endmodule

FILE: rtl/pcm_sample_mixer_core.sv
// Channel   | dir | tdata fields (low bit up)
// in_       | in  | action, channel, address, length, loop_flag, volume, sample_data
// out_      | out | mixed_sample, sample_valid, status
// A non-tick request's result is valid in the cycle after it leaves the queue; a tick steps
// each channel through READ and ACC, with WAIT between them for an active one (memory read,
// multiply, accumulate), and then OUT registers its result.
// Reset: rst_n synchronous, all channels idle; sample memory is not cleared.
// A two-entry queue lets input be taken while the back end works or the output stalls.
// Depends on psm_pkg, psm_front, psm_back.
`timescale 1ns / 1ps
module pcm_sample_mixer_core
  import psm_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // action[2:0] channel[5:3] address[21:6] length[38:22]
                                 // loop_flag[39] volume[55:40] sample_data[63:56]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // mixed_sample[7:0] sample_valid[8] status[9]
);
  logic q_valid, q_pop;
  req_t q_head;

  psm_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_pop, .q_valid, .q_head
  );

  psm_back #(.NUM_CHANNELS(NUM_CHANNELS), .SAMPLE_DEPTH(SAMPLE_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_head, .q_pop, .out_tvalid, .out_tready, .out_tdata
  );
endmodule

FILE: rtl/psm_checker.sv
// Port-level checks for the PCM sample mixer, bound to the top level.
// Depends on pcm_sample_mixer_core ports only.
`timescale 1ns / 1ps
module psm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out hold");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:10] == 6'd0) else $error("pad bits");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[8] && out_tdata[9])) else $error("valid and reject");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[7:0] == 8'd0) else $error("idle sample");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid) else $error("reset");
endmodule

bind pcm_sample_mixer_core psm_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);

FILE: verif/pcm_sample_mixer_core_test.sv
// Self-checking bench for pcm_sample_mixer_core: stream driver and monitor, built-in mixer predictor.
// Depends on psm_pkg and the pcm_sample_mixer_core RTL.
`timescale 1ns / 1ps
module pcm_sample_mixer_core_test;
  import psm_pkg::*;

  typedef struct packed {
    logic [7:0]  sample_data;
    logic [15:0] volume;
    logic        loop_flag;
    logic [16:0] length;
    logic [15:0] address;
    logic [2:0]  channel;
    logic [2:0]  action;
  } mix_req_t;

  typedef struct packed {
    logic       status;
    logic       sample_valid;
    logic [7:0] mixed_sample;
  } mix_rsp_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  pcm_sample_mixer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // predictor state
  logic [15:0] ch_start [8];
  logic [16:0] ch_len [8];
  logic [16:0] ch_pos [8];
  bit          ch_on [8];
  bit          ch_loop [8];
  logic [7:0]  ch_gain [8];
  logic [7:0]  pcm_mem [int];

  mix_req_t pending_reqs[$];
  mix_rsp_t expected_mix[$];
  int       sender_idle_pct;
  int       receiver_stall_pct;
  int       error_count;
  int       request_count;
  int       result_count;
  int       tick_count;
  int       valid_tick_count;
  int       quiet_cycles;

  function automatic mix_rsp_t predict_mix(mix_req_t r);
    mix_rsp_t    rsp;
    int unsigned acc;
    bit          any;
    rsp = '0;
    case (r.action)
      ACT_START: begin
        if (r.length == 0) rsp.status = 1'b1;
        else begin
          ch_start[r.channel] = r.address;
          ch_len[r.channel]   = (r.length > MAX_LEN) ? MAX_LEN : r.length;
          ch_pos[r.channel]   = '0;
          ch_loop[r.channel]  = r.loop_flag;
          ch_gain[r.channel]  = 8'd255;
          ch_on[r.channel]    = 1'b1;
        end
      end
      ACT_STOP: ch_on[r.channel] = 1'b0;
      ACT_VOL:  ch_gain[r.channel] = (r.volume > 255) ? 8'd255 : r.volume[7:0];
      ACT_LOAD: pcm_mem[r.address] = r.sample_data;
      ACT_TICK: begin
        acc = 0;
        any = 0;
        for (int c = 0; c < 8; c++) begin
          if (ch_on[c]) begin
            logic [15:0] a;
            any = 1;
            a = ch_start[c] + ch_pos[c][15:0];
            acc += (pcm_mem[a] * ch_gain[c]) >> 8;
            ch_pos[c]++;
            if (ch_pos[c] >= ch_len[c]) begin
              if (ch_loop[c]) ch_pos[c] = '0;
              else ch_on[c] = 1'b0;
            end
          end
        end
        if (any) begin
          rsp.sample_valid = 1'b1;
          rsp.mixed_sample = (acc > 255) ? 8'd255 : acc[7:0];
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic mix_req_t make_req(logic [2:0] act, logic [2:0] ch, logic [15:0] addr,
                                        logic [16:0] len, bit lp, logic [15:0] vol,
                                        logic [7:0] dat);
    mix_req_t r;
    r = '{dat, vol, lp, len, addr, ch, act};
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d expected %0d (result %0d)", what, got, want, result_count);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_mix.push_back(predict_mix(mix_req_t'(in_tdata)));
        request_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_reqs.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        mix_rsp_t got;
        mix_rsp_t want;
        got = out_tdata[9:0];
        result_count++;
        if (expected_mix.size() == 0) begin
          $display("unexpected result %h", out_tdata);
          error_count++;
        end else begin
          want = expected_mix.pop_front();
          if (got.mixed_sample !== want.mixed_sample)
            report_mismatch("mixed_sample", got.mixed_sample, want.mixed_sample);
          if (got.sample_valid !== want.sample_valid)
            report_mismatch("sample_valid", got.sample_valid, want.sample_valid);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (want.sample_valid) valid_tick_count++;
        end
      end
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT && (pending_reqs.size() > 0 || in_tvalid ||
        expected_mix.size() > 0)) begin
      $display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_req(mix_req_t r);
    if (r.action == ACT_TICK) tick_count++;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_mix.size() > 0) @(posedge clk);
  endtask

  // load a region and start a channel within it
  task automatic add_song(logic [2:0] ch, logic [15:0] base, int n, bit lp);
    for (int i = 0; i < n; i++)
      add_req(make_req(ACT_LOAD, 3'($urandom), base + 16'(i), 17'($urandom),
                       1'($urandom), 16'($urandom), 8'($urandom)));
    add_req(make_req(ACT_START, ch, base, 17'(n), lp, 16'($urandom), 8'($urandom)));
  endtask

  task automatic random_phase(int n_items);
    int done;
    done = 0;
    while (done < n_items) begin
      int k;
      k = $urandom_range(99);
      if (k < 12) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
        add_song(3'($urandom), 16'($urandom), n, 1'($urandom));
        done += n + 1;
      end else if (k < 20) begin
        add_req(make_req(ACT_VOL, 3'($urandom), 16'($urandom), 17'($urandom), 1'($urandom),
                         ($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(255))),
                         8'($urandom)));
        done++;
      end else if (k < 24) begin
        add_req(make_req(ACT_STOP, 3'($urandom), 16'($urandom), 17'($urandom),
                         1'($urandom), 16'($urandom), 8'($urandom)));
        done++;
      end else if (k < 27) begin
        add_req(make_req(ACT_START, 3'($urandom), 16'($urandom), 17'd0, 1'($urandom),
                         16'($urandom), 8'($urandom)));
        done++;
      end else if (k < 30) begin
        add_req(make_req(3'($urandom_range(5, 7)), 3'($urandom), 16'($urandom),
                         17'($urandom), 1'($urandom), 16'($urandom), 8'($urandom)));
        done++;
      end else begin
        add_req(make_req(ACT_TICK, 3'($urandom), 16'($urandom), 17'($urandom),
                         1'($urandom), 16'($urandom), 8'($urandom)));
        done++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    error_count = 0;
    request_count = 0;
    result_count = 0;
    tick_count = 0;
    valid_tick_count = 0;
    quiet_cycles = 0;
    for (int c = 0; c < 8; c++) begin
      ch_start[c] = '0; ch_len[c] = '0; ch_pos[c] = '0;
      ch_on[c] = 0; ch_loop[c] = 0; ch_gain[c] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, zero length, unused codes, extremes, wrap, long length
    add_req(make_req(ACT_TICK, 3'd0, 16'd0, 17'd0, 1'b0, 16'd0, 8'd0));
    add_req(make_req(ACT_START, 3'd7, 16'hFFFF, 17'd0, 1'b1, 16'hFFFF, 8'hFF));
    add_req(make_req(3'd5, 3'd0, 16'd0, 17'd0, 1'b0, 16'd0, 8'd0));
    add_req(make_req(3'd7, 3'd7, 16'hFFFF, 17'h1FFFF, 1'b1, 16'hFFFF, 8'hFF));
    add_req(make_req(ACT_LOAD, 3'd0, 16'hFFFF, 17'd0, 1'b0, 16'd0, 8'hFF));
    add_req(make_req(ACT_LOAD, 3'd7, 16'h0000, 17'h1FFFF, 1'b1, 16'hFFFF, 8'hFE));
    add_req(make_req(ACT_START, 3'd7, 16'hFFFF, 17'd2, 1'b1, 16'd0, 8'd0));
    add_req(make_req(ACT_START, 3'd0, 16'hFFFF, 17'h1FFFF, 1'b0, 16'd0, 8'd0));
    add_req(make_req(ACT_TICK, 3'd0, 16'd0, 17'd0, 1'b0, 16'd0, 8'd0));
    add_req(make_req(ACT_VOL, 3'd7, 16'd0, 17'd0, 1'b0, 16'hFFFF, 8'd0));
    add_req(make_req(ACT_VOL, 3'd0, 16'd0, 17'd0, 1'b0, 16'd0, 8'd0));
    add_req(make_req(ACT_TICK, 3'd0, 16'd0, 17'd0, 1'b0, 16'd0, 8'd0));
    add_req(make_req(ACT_VOL, 3'd0, 16'd0, 17'd0, 1'b0, 16'd128, 8'd0));
    add_req(make_req(ACT_STOP, 3'd0, 16'd0, 17'd0, 1'b0, 16'd0, 8'd0));
    add_req(make_req(ACT_TICK, 3'd0, 16'd0, 17'd0, 1'b0, 16'd0, 8'd0));
    add_req(make_req(ACT_STOP, 3'd7, 16'd0, 17'd0, 1'b0, 16'd0, 8'd0));
    add_req(make_req(ACT_TICK, 3'd0, 16'd0, 17'd0, 1'b0, 16'd0, 8'd0));
    // all channels full gain on full-scale data: clamp
    for (int c = 0; c < 8; c++)
      add_req(make_req(ACT_START, 3'(c), 16'hFFFF, 17'd1, 1'b0, 16'd0, 8'd0));
    add_req(make_req(ACT_TICK, 3'd0, 16'd0, 17'd0, 1'b0, 16'd0, 8'd0));
    wait_drained();

    // random phases with different idling mixes
    random_phase(190);
    wait_drained();
    sender_idle_pct = 84;
    random_phase(180);
    wait_drained();
    sender_idle_pct = 0;
    receiver_stall_pct = 84;
    random_phase(180);
    wait_drained();
    sender_idle_pct = 7;
    receiver_stall_pct = 7;
    random_phase(180);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d requests and %0d results, %0d ticks (%0d with active channels)",
             request_count, result_count, tick_count, valid_tick_count);
    $display("idle/stall phases: none, sender, receiver, both; %0d mismatches", error_count);
    if (error_count == 0 && expected_mix.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
